/* rtl/core/ncw_pkg.sv */
package ncw_pkg;

    localparam logic [7:0] DUP_LIMIT = 8'd3;

    localparam logic [31:0] ONE_SEG  = 32'h0001_0000;
    localparam logic [31:0] HALF_SEG = 32'h0000_8000;

    localparam logic [31:0] RESET_WINDOW    = 32'h0001_0000;
    localparam logic [15:0] RESET_THRESHOLD = 16'd16;

    localparam int          DIV_STEPS = 33;
    localparam logic [5:0]  DIV_FIRST = 6'(DIV_STEPS - 1);

    typedef enum logic [1:0] {
        PH_OPEN     = 2'd0,
        PH_DISORDER = 2'd1,
        PH_RECOVERY = 2'd2,
        PH_LOSS     = 2'd3
    } t_phase;

    typedef enum logic {
        FUNC_ACK  = 1'b0,
        FUNC_LOSS = 1'b1
    } t_func;

    typedef enum logic {
        CFG_INITIAL_WINDOW    = 1'b0,
        CFG_INITIAL_THRESHOLD = 1'b1
    } t_cfg_index;

    typedef enum logic [1:0] {
        ST_IDLE   = 2'd0,
        ST_DIV    = 2'd1,
        ST_COMMIT = 2'd2
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
        logic commit;
    } t_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
    } t_status;

    typedef struct packed {
        logic        retransmit;
        logic        wake_sender;
        logic [31:0] window_now;
        logic [15:0] threshold_now;
        t_phase      phase_now;
        logic [7:0]  dup_count;
    } t_result;

endpackage

/* rtl/core/ncw_ctrl.sv */
module ncw_ctrl
    import ncw_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    input  logic    i_out_free,
    input  t_status i_status,
    output t_cmd    o_cmd,
    output logic    o_busy
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_valid) begin
                    n_state = i_status.need_div ? ST_DIV : ST_COMMIT;
                end
            end
            ST_DIV: begin
                if (i_status.div_last) begin
                    n_state = ST_COMMIT;
                end
            end
            ST_COMMIT: begin
                if (i_out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_cmd  = '0;
        o_busy = 1'b1;
        unique case (r_state)
            ST_IDLE: begin
                o_busy     = 1'b0;
                o_cmd.load = i_valid;
            end
            ST_DIV: begin
                o_cmd.step = 1'b1;
            end
            ST_COMMIT: begin
                o_cmd.commit = i_out_free;
            end
            default: begin
                o_busy = 1'b1;
            end
        endcase
    end

endmodule

/* rtl/core/ncw_datapath.sv */
module ncw_datapath
    import ncw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    output t_status     o_status,
    input  logic        i_func,
    input  logic [31:0] i_ack_number,
    input  logic        i_ack_advances,
    input  logic [31:0] i_next_send_seq,
    input  logic [31:0] i_loss_mark,
    input  logic        i_cfg_write,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output t_result     o_result
);

    logic [31:0] r_window;
    logic [15:0] r_threshold;
    t_phase      r_phase;
    logic [7:0]  r_dup;
    logic        r_shrink_done;
    logic [31:0] r_recovery_point;
    logic [31:0] r_loss_point;

    t_func       r_func;
    logic [31:0] r_ack;
    logic        r_adv;
    logic [31:0] r_nxt;
    logic [31:0] r_lmark;

    logic [31:0] r_rem;
    logic [32:0] r_quo;
    logic [5:0]  r_cnt;

    logic [31:0] n_window;
    logic [15:0] n_threshold;
    t_phase      n_phase;
    logic [7:0]  n_dup;
    logic        n_shrink_done;
    logic [31:0] n_recovery_point;
    logic [31:0] n_loss_point;
    logic        n_retx;
    logic        n_wake;

    logic [31:0] thr_fixed;
    logic [32:0] div_shift;
    logic        div_ge;
    logic [31:0] recip;
    logic [32:0] grow_sum;
    logic [31:0] grown;
    logic [7:0]  dup_inc;
    logic [31:0] grown_shrunk;
    logic [31:0] window_shrunk;
    logic [14:0] half_thr;

    assign thr_fixed = {r_threshold, 16'h0000};

    always_comb begin
        o_status.need_div = (t_func'(i_func) == FUNC_ACK) && (r_phase != PH_RECOVERY)
                            && !(r_window < thr_fixed);
        o_status.div_last = (r_cnt == 6'd0);
    end

    assign div_shift = {r_rem, (r_cnt == DIV_FIRST)};
    assign div_ge    = (div_shift >= {1'b0, r_window});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func  <= t_func'(i_func);
            r_ack   <= i_ack_number;
            r_adv   <= i_ack_advances;
            r_nxt   <= i_next_send_seq;
            r_lmark <= i_loss_mark;
            r_rem   <= '0;
            r_quo   <= '0;
            r_cnt   <= DIV_FIRST;
        end else if (i_cmd.step) begin
            r_rem <= div_ge ? 32'(div_shift - {1'b0, r_window}) : div_shift[31:0];
            r_quo <= {r_quo[31:0], div_ge};
            r_cnt <= r_cnt - 6'd1;
        end
    end

    always_comb begin
        recip = r_quo[32] ? 32'hFFFF_FFFF : r_quo[31:0];
        if (r_window < thr_fixed) begin
            grow_sum = {1'b0, r_window} + {1'b0, ONE_SEG};
        end else begin
            grow_sum = {1'b0, r_window} + {1'b0, recip};
        end
        grown         = grow_sum[32] ? 32'hFFFF_FFFF : grow_sum[31:0];
        dup_inc       = (r_dup == 8'hFF) ? r_dup : r_dup + 8'd1;
        grown_shrunk  = (grown > HALF_SEG) ? grown - HALF_SEG : 32'd0;
        window_shrunk = (r_window > HALF_SEG) ? r_window - HALF_SEG : 32'd0;
        half_thr      = grown[31:17];
    end

    always_comb begin
        n_window         = r_window;
        n_threshold      = r_threshold;
        n_phase          = r_phase;
        n_dup            = r_dup;
        n_shrink_done    = r_shrink_done;
        n_recovery_point = r_recovery_point;
        n_loss_point     = r_loss_point;
        n_retx           = 1'b0;
        n_wake           = 1'b0;
        if (r_func == FUNC_LOSS) begin
            n_phase      = PH_LOSS;
            n_loss_point = r_lmark;
        end else begin
            case (r_phase)
                PH_OPEN: begin
                    n_window = grown;
                    if (!r_adv) begin
                        n_dup   = dup_inc;
                        n_phase = PH_DISORDER;
                    end
                end
                PH_DISORDER: begin
                    n_window = grown;
                    if (!r_adv) begin
                        n_dup = dup_inc;
                        if (dup_inc >= DUP_LIMIT) begin
                            n_threshold      = (half_thr == 15'd0) ? 16'd1 : {1'b0, half_thr};
                            n_window         = grown_shrunk;
                            n_shrink_done    = 1'b0;
                            n_recovery_point = r_nxt;
                            n_phase          = PH_RECOVERY;
                            n_retx           = 1'b1;
                        end
                    end
                end
                PH_LOSS: begin
                    n_window = grown;
                    if (r_adv) begin
                        if (r_ack >= r_loss_point) begin
                            n_phase = PH_OPEN;
                            n_dup   = 8'd0;
                        end
                    end else begin
                        n_dup = dup_inc;
                    end
                end
                PH_RECOVERY: begin
                    if (r_window > thr_fixed && !r_shrink_done) begin
                        n_window = window_shrunk;
                    end else begin
                        n_shrink_done = 1'b1;
                    end
                    if (r_adv) begin
                        if (r_ack < r_recovery_point) begin
                            n_retx = 1'b1;
                        end else begin
                            n_phase = PH_OPEN;
                            n_dup   = 8'd0;
                        end
                    end else begin
                        n_dup  = dup_inc;
                        n_wake = 1'b1;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window         <= RESET_WINDOW;
            r_threshold      <= RESET_THRESHOLD;
            r_phase          <= PH_OPEN;
            r_dup            <= '0;
            r_shrink_done    <= 1'b0;
            r_recovery_point <= '0;
            r_loss_point     <= '0;
        end else if (i_cmd.commit) begin
            r_window         <= n_window;
            r_threshold      <= n_threshold;
            r_phase          <= n_phase;
            r_dup            <= n_dup;
            r_shrink_done    <= n_shrink_done;
            r_recovery_point <= n_recovery_point;
            r_loss_point     <= n_loss_point;
        end else if (i_cfg_write) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_INITIAL_WINDOW: begin
                    r_window <= i_cfg_data;
                end
                CFG_INITIAL_THRESHOLD: begin
                    r_threshold <= i_cfg_data[15:0];
                end
                default: begin
                    r_window <= r_window;
                end
            endcase
        end
    end

    always_comb begin
        o_result.retransmit    = n_retx;
        o_result.wake_sender   = n_wake;
        o_result.window_now    = n_window;
        o_result.threshold_now = n_threshold;
        o_result.phase_now     = n_phase;
        o_result.dup_count     = n_dup;
    end

endmodule

/* rtl/core/newreno_congestion_window.sv */
// Congestion window tracker for a NewReno sender.
// The input channel carries one event per transaction: an ACK (func 0) with its
// acknowledgement number, advance flag and the sender's next sequence, or a
// loss entry (func 1) with the sequence point that ends the loss phase.
// Every event produces exactly one result transaction on the output channel
// with the window, threshold, phase, duplicate count and the retransmit and
// wake requests.
// An ACK that grows the window at or above the threshold runs a bit-serial
// reciprocal of the 32-bit window, one quotient bit per cycle, so such an
// event reaches the result register once the division ends; all other events
// go from acceptance straight to the commit step. No new event is accepted
// until the result of the last one has been committed.
// The input stall is high while an event is in progress. A finished result
// waits in the output register while the receiver stalls; the block holds the
// next event until that register is free.
// The configuration port is always ready and loads the live window or
// threshold; write it only while the block is idle.
// Reset sets the window to one segment, the threshold to 16 segments and the
// phase to open, and empties the output register.
module newreno_congestion_window
    import ncw_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_func,
    input  logic [31:0] i_ack_number,
    input  logic        i_ack_advances,
    input  logic [31:0] i_next_send_seq,
    input  logic [31:0] i_loss_mark,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_retransmit,
    output logic        o_wake_sender,
    output logic [31:0] o_window_now,
    output logic [15:0] o_threshold_now,
    output logic [1:0]  o_phase_now,
    output logic [7:0]  o_dup_count,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [31:0] i_cfg_data
);

    t_cmd    cmd;
    t_status status;
    t_result result;
    logic    busy;
    logic    out_free;

    t_result r_out;
    logic    r_out_valid;

    assign out_free    = !r_out_valid || !i_stall;
    assign o_stall     = busy;
    assign o_cfg_ready = 1'b1;

    ncw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .i_out_free (out_free),
        .i_status   (status),
        .o_cmd      (cmd),
        .o_busy     (busy)
    );

    ncw_datapath u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_status        (status),
        .i_func          (i_func),
        .i_ack_number    (i_ack_number),
        .i_ack_advances  (i_ack_advances),
        .i_next_send_seq (i_next_send_seq),
        .i_loss_mark     (i_loss_mark),
        .i_cfg_write     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .o_result        (result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (!i_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.commit) begin
            r_out <= result;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_retransmit    = r_out.retransmit;
    assign o_wake_sender   = r_out.wake_sender;
    assign o_window_now    = r_out.window_now;
    assign o_threshold_now = r_out.threshold_now;
    assign o_phase_now     = r_out.phase_now;
    assign o_dup_count     = r_out.dup_count;

endmodule
